/* hw/rtl/hme_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package hme_pkg;
    localparam logic [1:0] OP_FIND   = 2'd0;
    localparam logic [1:0] OP_ADD    = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EXISTS   = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    localparam logic [10:0] CAP_RESET = 11'd64;
    localparam int ADDR_CAPACITY = 0;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_FILL,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_DECIDE,
        S_LAST_RD,
        S_LAST_WAIT,
        S_MOVE,
        S_DONE
    } state_t;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } div_ctl_t;
endpackage
`default_nettype wire

/* hw/rtl/hash_map_engine_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// Channel | Dir | Fields (low bit up)
// s_axis  | in  | tdata: op[1:0], key, value
// m_axis  | out | tdata: status[1:0], value_out, items (zero filled to bytes)
// apb     | cfg | reg 0 capacity at address 0
// A request is accepted, its home slot is found by a bit-serial remainder and
// the fill table is read. The scan then reads and compares each filled bucket way
// in turn and ends on a hit or at the bucket's fill. One state decides, a remove
// moves the last way into the freed way, and the result is held until taken.
// After reset a clearing pass empties the fill table slot by slot; no
// request is accepted meanwhile. s_tready is low from acceptance until the
// result has been taken on m_axis.
module hash_map_engine_unit #(
    parameter int SLOTS      = 1024,
    parameter int WAYS       = 8,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    input  wire  [71:0]  s_axis_tdata,  // op[1:0], key[33:2], value[65:34]
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    output logic [47:0]  m_axis_tdata,  // status[1:0], value_out[33:2], items[45:34]
    input  wire          psel,
    input  wire          penable,
    input  wire          pwrite,
    input  wire  [0:0]   paddr,
    input  wire  [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import hme_pkg::*;

    localparam int SB = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int WB = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int FB = $clog2(WAYS + 1);
    localparam int EB = SB + WB;

    logic [10:0] cap_reg;
    logic [10:0] cap_eff;
    assign pready = 1'b1;
    assign prdata = {21'd0, cap_reg};
    always_ff @(posedge aclk) begin
        if (!aresetn) cap_reg <= CAP_RESET;
        else if (psel && penable && pwrite && paddr == 1'(ADDR_CAPACITY))
            cap_reg <= pwdata[10:0];
    end
    always_comb begin
        cap_eff = cap_reg;
        if (cap_reg == 11'd0) cap_eff = 11'd1;
        if ({21'd0, cap_reg} > 32'(SLOTS)) cap_eff = 11'(SLOTS);
    end

    // Memories
    logic [KEY_BITS-1:0]   key_mem [SLOTS*WAYS];
    logic [VALUE_BITS-1:0] val_mem [SLOTS*WAYS];
    logic [FB-1:0]         fill_mem [SLOTS];

    state_t state_reg, state_next;
    logic [1:0]            op_reg, op_next;
    logic [KEY_BITS-1:0]   key_reg, key_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic [SB-1:0]         slot_reg, slot_next;
    logic [FB-1:0]         fill_reg, fill_next;
    logic [FB-1:0]         way_reg, way_next;
    logic [WB-1:0]         hit_reg, hit_next;
    logic                  found_reg, found_next;
    logic [11:0]           items_reg, items_next;
    logic [1:0]            st_reg, st_next;
    logic [31:0]           vout_reg, vout_next;
    logic [SB:0]           clr_reg, clr_next;

    logic                  div_start;
    div_ctl_t              div_ctl;
    logic [10:0]           rem;

    logic [EB-1:0]         rd_addr;
    logic [KEY_BITS-1:0]   rd_key;
    logic [VALUE_BITS-1:0] rd_val;
    logic                  wr_en;
    logic [EB-1:0]         wr_addr;
    logic [KEY_BITS-1:0]   wr_key;
    logic [VALUE_BITS-1:0] wr_val;
    logic                  fwr_en;
    logic [SB-1:0]         fwr_addr;
    logic [FB-1:0]         fwr_data;
    logic [FB-1:0]         frd;

    hme_divider #(.KEY_BITS(KEY_BITS), .DIV_BITS(11)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .dividend(key_next), .divisor(cap_eff), .ctl(div_ctl), .remainder(rem)
    );

    always_ff @(posedge aclk) begin
        rd_key <= key_mem[rd_addr];
        rd_val <= val_mem[rd_addr];
        if (wr_en) begin
            key_mem[wr_addr] <= wr_key;
            val_mem[wr_addr] <= wr_val;
        end
        frd <= fill_mem[slot_next];
        if (fwr_en) fill_mem[fwr_addr] <= fwr_data;
    end

    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        key_next   = key_reg;
        val_next   = val_reg;
        slot_next  = slot_reg;
        fill_next  = fill_reg;
        way_next   = way_reg;
        hit_next   = hit_reg;
        found_next = found_reg;
        items_next = items_reg;
        st_next    = st_reg;
        vout_next  = vout_reg;
        clr_next   = clr_reg;
        div_start  = 1'b0;
        rd_addr    = {slot_reg, way_reg[WB-1:0]};
        wr_en      = 1'b0;
        wr_addr    = {slot_reg, way_reg[WB-1:0]};
        wr_key     = key_reg;
        wr_val     = val_reg;
        fwr_en     = 1'b0;
        fwr_addr   = slot_reg;
        fwr_data   = fill_reg;
        s_axis_tready = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (!clr_reg[SB]) begin
                    fwr_en   = 1'b1;
                    fwr_addr = clr_reg[SB-1:0];
                    fwr_data = '0;
                    clr_next = clr_reg + 1'b1;
                end else begin
                    s_axis_tready = 1'b1;
                    if (s_axis_tvalid) begin
                        op_next  = s_axis_tdata[1:0];
                        key_next = s_axis_tdata[KEY_BITS+1:2];
                        val_next = s_axis_tdata[VALUE_BITS+33:34];
                        div_start  = 1'b1;
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (div_ctl.done) begin
                    slot_next  = rem[SB-1:0];
                    state_next = S_FILL;
                end
            end
            S_FILL: begin
                // Fill table read lands this cycle.
                state_next = S_SCAN_RD;
                way_next   = '0;
                found_next = 1'b0;
            end
            S_SCAN_RD: begin
                if (way_reg == '0) fill_next = frd;
                if ((way_reg == '0 ? frd : fill_reg) == way_reg) begin
                    state_next = S_DECIDE;
                end else begin
                    state_next = S_SCAN_CMP;
                end
            end
            S_SCAN_CMP: begin
                if (rd_key == key_reg) begin
                    found_next = 1'b1;
                    hit_next   = way_reg[WB-1:0];
                    vout_next  = 32'(rd_val);
                    state_next = S_DECIDE;
                end else begin
                    way_next   = way_reg + 1'b1;
                    state_next = S_SCAN_RD;
                end
            end
            S_DECIDE: begin
                st_next    = ST_NOTFOUND;
                state_next = S_DONE;
                if (!found_reg) vout_next = '0;
                case (op_reg)
                    OP_FIND: if (found_reg) st_next = ST_OK;
                    OP_ADD: begin
                        vout_next = '0;
                        if (found_reg) st_next = ST_EXISTS;
                        else if ({1'b0, items_reg} + 13'd1 > 13'(3 * cap_eff)
                                 || fill_reg >= FB'(WAYS)) st_next = ST_FULL;
                        else begin
                            wr_en    = 1'b1;
                            wr_addr  = {slot_reg, fill_reg[WB-1:0]};
                            fwr_en   = 1'b1;
                            fwr_data = fill_reg + 1'b1;
                            items_next = items_reg + 1'b1;
                            st_next  = ST_OK;
                        end
                    end
                    OP_REMOVE: begin
                        if (found_reg) begin
                            st_next  = ST_OK;
                            way_next = fill_reg - 1'b1;
                            fwr_en   = 1'b1;
                            fwr_data = fill_reg - 1'b1;
                            if (items_reg != '0) items_next = items_reg - 1'b1;
                            state_next = S_LAST_RD;
                        end
                    end
                    default: vout_next = '0;
                endcase
            end
            S_LAST_RD: state_next = S_LAST_WAIT;
            S_LAST_WAIT: state_next = S_MOVE;
            S_MOVE: begin
                wr_en   = 1'b1;
                wr_addr = {slot_reg, hit_reg};
                wr_key  = rd_key;
                wr_val  = rd_val;
                state_next = S_DONE;
            end
            S_DONE: if (m_axis_tready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        op_reg   <= op_next;
        key_reg  <= key_next;
        val_reg  <= val_next;
        slot_reg <= slot_next;
        fill_reg <= fill_next;
        way_reg  <= way_next;
        hit_reg  <= hit_next;
        found_reg <= found_next;
        st_reg   <= st_next;
        vout_reg <= vout_next;
        if (!aresetn) begin
            state_reg <= S_IDLE;
            items_reg <= '0;
            clr_reg   <= '0;
        end else begin
            state_reg <= state_next;
            items_reg <= items_next;
            clr_reg   <= clr_next;
        end
    end

    assign m_axis_tvalid = (state_reg == S_DONE);
    assign m_axis_tdata  = {2'b00, items_reg, vout_reg, st_reg};

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("accepting while result pending");
    a_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        fwr_en && clr_reg[SB] |-> fwr_data <= FB'(WAYS))
        else $error("bucket overfilled");
    a_items: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DONE |-> items_reg <= 12'd3072)
        else $error("item count out of range");
endmodule
`default_nettype wire

/* hw/rtl/hme_divider.sv */
`timescale 1ns / 1ps
`default_nettype none
// Restoring remainder unit: one quotient bit per cycle.
module hme_divider #(
    parameter int KEY_BITS = 32,
    parameter int DIV_BITS = 11
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 start,
    input  wire [KEY_BITS-1:0]  dividend,
    input  wire [DIV_BITS-1:0]  divisor,
    output hme_pkg::div_ctl_t   ctl,
    output logic [DIV_BITS-1:0] remainder
);
    import hme_pkg::*;

    localparam int CW = $clog2(KEY_BITS + 1);

    logic [KEY_BITS-1:0] num_reg, num_next;
    logic [DIV_BITS:0]   rem_reg, rem_next;
    logic [DIV_BITS-1:0] den_reg, den_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [DIV_BITS+1:0] trial;

    always_comb begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, num_reg[KEY_BITS-1]} - {2'b00, den_reg};
        if (start) begin
            num_next  = dividend;
            den_next  = divisor;
            rem_next  = '0;
            cnt_next  = CW'(KEY_BITS);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[DIV_BITS+1]) begin
                rem_next = trial[DIV_BITS:0];
            end else begin
                rem_next = {rem_reg[DIV_BITS-1:0], num_reg[KEY_BITS-1]};
            end
            num_next = num_reg << 1;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign ctl.start = start;
    assign ctl.busy  = busy_reg;
    assign ctl.done  = done_reg;
    assign remainder = rem_reg[DIV_BITS-1:0];

    // The remainder never reaches the divisor.
    a_rem_lt: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> (rem_reg < {1'b0, den_reg}))
        else $error("remainder not below divisor");
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg)
        else $error("divider done while busy");
    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> busy_reg)
        else $error("divider did not start");
endmodule
`default_nettype wire

/* dv/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
    import hme_pkg::*;

    localparam int SLOTS = 1024;
    localparam int WAYS  = 8;
    localparam logic [1:0] OP_UNKNOWN = 2'd3;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] value_out;
        logic [11:0] items;
    } map_result_t;

    typedef struct {
        bit          is_cfg;
        logic [1:0]  op;
        logic [31:0] key;
        logic [31:0] value;
        bit          typed;
        map_result_t res;
    } map_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;  // op[1:0], key[33:2], value[65:34]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;  // status[1:0], value_out[33:2], items[45:34]
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [0:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    hash_map_engine_unit u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Shadow copy of the map.
    logic [10:0] cap_reg;
    logic [3:0]  fill_cnt [SLOTS];
    logic [31:0] stored_key [SLOTS*WAYS];
    logic [31:0] stored_val [SLOTS*WAYS];
    logic [11:0] item_cnt;

    map_result_t pending_results[$];
    int          err_count;
    int          got_count = 0;
    bit          calm;

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    initial begin
        #20ms;
        $display("tb: failure");
        $finish;
    end

    task automatic report(input string msg);
        $display("mismatch: %s", msg);
        err_count++;
    endtask

    function automatic map_result_t map_apply(input logic [1:0] op,
                                              input logic [31:0] key,
                                              input logic [31:0] value);
        int unsigned cap;
        int unsigned slot;
        int          hit;
        int unsigned last;
        map_result_t r;
        cap = (cap_reg == 0) ? 1 : ((cap_reg > SLOTS) ? SLOTS : cap_reg);
        slot = key % cap;
        hit = -1;
        for (int w = fill_cnt[slot]; w > 0; w--)
            if (stored_key[slot*WAYS + w - 1] == key) hit = w - 1;
        r.status = ST_NOTFOUND;
        r.value_out = '0;
        if (op == OP_FIND) begin
            if (hit >= 0) begin
                r.status = ST_OK;
                r.value_out = stored_val[slot*WAYS + hit];
            end
        end else if (op == OP_ADD) begin
            if (hit >= 0) begin
                r.status = ST_EXISTS;
            end else if (item_cnt + 1 > 3 * cap || fill_cnt[slot] >= WAYS) begin
                r.status = ST_FULL;
            end else begin
                stored_key[slot*WAYS + fill_cnt[slot]] = key;
                stored_val[slot*WAYS + fill_cnt[slot]] = value;
                fill_cnt[slot]++;
                item_cnt++;
                r.status = ST_OK;
            end
        end else if (op == OP_REMOVE) begin
            if (hit >= 0) begin
                // The last way of the bucket moves into the freed way.
                last = slot*WAYS + fill_cnt[slot] - 1;
                r.value_out = stored_val[slot*WAYS + hit];
                stored_key[slot*WAYS + hit] = stored_key[last];
                stored_val[slot*WAYS + hit] = stored_val[last];
                fill_cnt[slot]--;
                if (item_cnt > 0) item_cnt--;
                r.status = ST_OK;
            end
        end
        r.items = item_cnt;
        return r;
    endfunction

    function automatic bit idle_now();
        return !calm && ($urandom_range(0, 99) < 34);
    endfunction

    task automatic send_word(input logic [1:0] op, input logic [31:0] key,
                             input logic [31:0] value, input bit typed,
                             input map_result_t typed_res);
        map_result_t r;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'b0, value, key, op};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        r = map_apply(op, key, value);
        pending_results.push_back(typed ? typed_res : r);
        if (idle_now()) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
    endtask

    // Waits for the map to drain, then writes the capacity register.
    task automatic write_capacity(input logic [31:0] v);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= 1'(ADDR_CAPACITY);
        pwdata <= v;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        cap_reg = v[10:0];
        @(posedge aclk);
    endtask

    // Result side: random stalls plus one long hold-off to back up the input.
    int hold_left = 0;
    bit held_once = 1'b0;
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got_count++;
            if (pending_results.size() == 0) begin
                report($sformatf("unexpected word %h", m_axis_tdata));
            end else begin
                map_result_t e;
                e = pending_results.pop_front();
                if (m_axis_tdata[1:0] !== e.status)
                    report($sformatf("status %0d, wanted %0d",
                                     m_axis_tdata[1:0], e.status));
                if (m_axis_tdata[33:2] !== e.value_out)
                    report($sformatf("value_out %h, wanted %h",
                                     m_axis_tdata[33:2], e.value_out));
                if (m_axis_tdata[45:34] !== e.items)
                    report($sformatf("items %0d, wanted %0d",
                                     m_axis_tdata[45:34], e.items));
            end
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (got_count == 60 && !held_once) begin
            held_once = 1'b1;
            hold_left = 400;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= !idle_now();
        end
    end

    map_row_t rows[$];
    logic [31:0] phase_caps[8] = '{32'd0, 32'd2047, 32'd3, 32'd1024,
                                   32'd7, 32'd64, 32'd1, 32'd1000};

    function automatic map_row_t item_row(input logic [1:0] op, input logic [31:0] key,
                                          input logic [31:0] value, input bit typed,
                                          input logic [1:0] st, input logic [31:0] vo,
                                          input logic [11:0] n);
        map_row_t r;
        r.is_cfg = 1'b0;
        r.op = op;
        r.key = key;
        r.value = value;
        r.typed = typed;
        r.res = '{st, vo, n};
        return r;
    endfunction

    initial begin
        map_row_t    cfg;
        logic [1:0]  op;
        logic [31:0] key;
        int unsigned pick;
        int unsigned capv;

        aresetn <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        err_count = 0;
        calm = 1'b0;
        cap_reg = CAP_RESET;
        item_cnt = '0;
        for (int i = 0; i < SLOTS; i++) fill_cnt[i] = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        cfg = '{1'b1, OP_FIND, 32'd0, 32'd1, 1'b0, '0};
        rows.push_back(item_row(OP_FIND, 32'd0, 32'hFFFF_FFFF, 1'b1, ST_NOTFOUND, '0, '0));
        rows.push_back(item_row(OP_REMOVE, 32'hFFFF_FFFF, '0, 1'b1, ST_NOTFOUND, '0, '0));
        rows.push_back(item_row(OP_UNKNOWN, 32'd5, 32'd9, 1'b1, ST_NOTFOUND, '0, '0));
        rows.push_back(item_row(OP_ADD, 32'd0, 32'hFFFF_FFFF, 1'b1, ST_OK, '0, 12'd1));
        rows.push_back(item_row(OP_FIND, 32'd0, '0, 1'b1, ST_OK, 32'hFFFF_FFFF, 12'd1));
        rows.push_back(item_row(OP_ADD, 32'd0, 32'd1, 1'b1, ST_EXISTS, '0, 12'd1));
        rows.push_back(item_row(OP_ADD, 32'hFFFF_FFFF, 32'd0, 1'b1, ST_OK, '0, 12'd2));
        rows.push_back(item_row(OP_ADD, 32'd64, 32'h1234_5678, 1'b1, ST_OK, '0, 12'd3));
        // A missing key whose bucket holds other keys.
        rows.push_back(item_row(OP_FIND, 32'd128, '0, 1'b1, ST_NOTFOUND, '0, 12'd3));
        rows.push_back(item_row(OP_REMOVE, 32'd0, '0, 1'b1, ST_OK, 32'hFFFF_FFFF, 12'd2));
        rows.push_back(item_row(OP_FIND, 32'd64, '0, 1'b0, ST_OK, '0, '0));
        rows.push_back(item_row(OP_UNKNOWN, 32'd64, 32'hFFFF_FFFF, 1'b1, ST_NOTFOUND, '0,
                                12'd2));
        rows.push_back(item_row(OP_REMOVE, 32'd64, '0, 1'b0, ST_OK, '0, '0));
        rows.push_back(item_row(OP_REMOVE, 32'hFFFF_FFFF, '0, 1'b1, ST_OK, 32'd0, 12'd0));
        // With a single slot the load limit allows three entries.
        rows.push_back(cfg);
        rows.push_back(item_row(OP_ADD, 32'd10, 32'hA5A5_5A5A, 1'b1, ST_OK, '0, 12'd1));
        rows.push_back(item_row(OP_ADD, 32'd11, 32'd11, 1'b1, ST_OK, '0, 12'd2));
        rows.push_back(item_row(OP_ADD, 32'd12, 32'd12, 1'b1, ST_OK, '0, 12'd3));
        rows.push_back(item_row(OP_ADD, 32'd13, 32'd13, 1'b1, ST_FULL, '0, 12'd3));
        rows.push_back(item_row(OP_FIND, 32'd11, '0, 1'b1, ST_OK, 32'd11, 12'd3));
        rows.push_back(item_row(OP_REMOVE, 32'd10, '0, 1'b0, ST_OK, '0, '0));
        rows.push_back(item_row(OP_FIND, 32'd12, '0, 1'b0, ST_OK, '0, '0));

        foreach (rows[i]) begin
            if (rows[i].is_cfg)
                write_capacity(rows[i].value);
            else
                send_word(rows[i].op, rows[i].key, rows[i].value,
                          rows[i].typed, rows[i].res);
        end

        foreach (phase_caps[p]) begin
            write_capacity(phase_caps[p]);
            calm = (p == 3);
            capv = (phase_caps[p] == 0) ? 1 :
                   ((phase_caps[p] > SLOTS) ? SLOTS : phase_caps[p]);
            for (int i = 0; i < 92; i++) begin
                pick = $urandom_range(0, 99);
                op = (pick < 45) ? OP_ADD : (pick < 70) ? OP_FIND :
                     (pick < 95) ? OP_REMOVE : OP_UNKNOWN;
                pick = $urandom_range(0, 99);
                if (pick < 15)
                    key = $urandom();
                else if (pick < 25)
                    key = 32'hFFFF_FFFF - $urandom_range(0, 15);
                else if (capv == 3)
                    key = 3 * $urandom_range(0, 11);  // crowds one bucket
                else
                    key = $urandom_range(0, 47);
                send_word(op, key, $urandom(), 1'b0, '0);
            end
        end
        calm = 1'b0;

        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (err_count == 0 && pending_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
